>>> hdl/mmf_pkg.sv
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared types, sizes and helpers for the matrix marginal fitting block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmf_pkg;

	localparam int MAX_BANKS  = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int VALUE_BITS = 48;
	localparam int ITER_W     = 16;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		CFG_BANK_COUNT = 2'd0,
		CFG_MAX_ITER   = 2'd1,
		CFG_TOLERANCE  = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP,
		ST_SUM,
		ST_ELEM_RD,
		ST_ELEM_LAT,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_WR
	} state_t;

	typedef enum logic [2:0] {
		PH_TOTAL,
		PH_PRIOR,
		PH_ROW,
		PH_COL,
		PH_RES
	} phase_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [IDX_W-1:0]      row_index;
		logic [IDX_W-1:0]      col_index;
		logic [VALUE_BITS-1:0] row_target;
		logic [VALUE_BITS-1:0] col_target;
	} req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] result_value;
		logic [ITER_W-1:0]     iterations_used;
		logic                  converged;
		logic                  status;
	} rsp_t;

	// saturating add at full scale
	function automatic logic [VALUE_BITS-1:0] sat_add(
		input logic [VALUE_BITS-1:0] a,
		input logic [VALUE_BITS-1:0] b
	);
		logic [VALUE_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VALUE_BITS] ? {VALUE_BITS{1'b1}} : s[VALUE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/matrix_marginal_fitting.sv
// ----------------------------------------------------------------------------
// matrix_marginal_fitting
// Iterative proportional fitting of an n x n matrix to row and column targets.
// ----------------------------------------------------------------------------
// One request is handled at a time; the next is taken once the block is back
// in idle, even while the previous response still waits on rsp_stall. A load
// goes from idle to the response state; a read first passes a read state for
// its entry RAM read. A start is run by a sequencer around the entry RAM and a
// shared multiply-divide unit: every sum over a row or column streams one RAM
// word per cycle, and every rescaled entry is read, multiplied as 48x16
// partial products, divided by a restoring divide and written back. A start
// sums the targets, builds the prior and its residual, then per pass rescales
// rows and columns (skipping those whose sum is zero) and sums the residual.
// Entries that were never written by a start read back as undefined.
`default_nettype none

module matrix_marginal_fitting (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire mmf_pkg::req_t                       req,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output mmf_pkg::rsp_t                            rsp,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [mmf_pkg::VALUE_BITS-1:0]      cfg_data
);

	localparam int VB = mmf_pkg::VALUE_BITS;
	localparam int PB = 2 * VB;

	// control state
	mmf_pkg::state_t state_q, state_d;
	mmf_pkg::phase_t phase_q, phase_d;
	logic [mmf_pkg::CNT_W-1:0]  o_q, o_d, k_q, k_d;
	logic                       v_s1, v_d;
	logic                       first_q, first_d;
	logic [mmf_pkg::ITER_W-1:0] it_q, it_d, last_iter_q, last_iter_d;
	logic [1:0]                 mcnt_q, mcnt_d;
	logic [5:0]                 dcnt_q, dcnt_d;
	logic                       out_valid_q, out_valid_d;
	logic [mmf_pkg::CNT_W-1:0]  bank_q;
	logic [mmf_pkg::ITER_W-1:0] maxit_q;
	logic [VB-1:0]              tol_q;

	// datapath
	logic [VB-1:0] acc_q, acc_d, total_q, total_d, d_q, d_d;
	logic [VB-1:0] opa_q, opa_d, opb_q, opb_d;
	logic [PB-1:0] prod_q, prod_d;
	logic [VB-1:0] rem_q, rem_d, quo_q, quo_d, worst_q, worst_d;
	logic [VB-1:0] pend_val_q, pend_val_d;
	logic          pend_conv_q, pend_conv_d, pend_stat_q, pend_stat_d;
	mmf_pkg::rsp_t out_q, out_d;

	// memories
	logic [mmf_pkg::ADDR_W-1:0] e_addr;
	logic [mmf_pkg::IDX_W-1:0]  r_addr, c_addr;
	logic [VB-1:0]              e_rd, r_rd, c_rd;
	logic                       e_we, t_we;

	logic [mmf_pkg::CNT_W-1:0] n_eff;
	logic                      req_acc, ri_bad, ci_bad;
	logic [63:0]               pp;

	// effective matrix size
	always_comb begin
		if (bank_q == '0) begin
			n_eff = mmf_pkg::CNT_W'(1);
		end else if (bank_q > mmf_pkg::CNT_W'(mmf_pkg::MAX_BANKS)) begin
			n_eff = mmf_pkg::CNT_W'(mmf_pkg::MAX_BANKS);
		end else begin
			n_eff = bank_q;
		end
	end

	assign req_stall = (state_q != mmf_pkg::ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign ri_bad    = {1'b0, req.row_index} >= n_eff;
	assign ci_bad    = {1'b0, req.col_index} >= n_eff;
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// RAM addressing
	always_comb begin
		if (state_q == mmf_pkg::ST_IDLE) begin
			e_addr = {req.row_index, req.col_index};
			r_addr = req.row_index;
			c_addr = req.row_index;
		end else begin
			if (phase_q == mmf_pkg::PH_COL) begin
				e_addr = {k_q[mmf_pkg::IDX_W-1:0], o_q[mmf_pkg::IDX_W-1:0]};
			end else begin
				e_addr = {o_q[mmf_pkg::IDX_W-1:0], k_q[mmf_pkg::IDX_W-1:0]};
			end
			r_addr = (phase_q == mmf_pkg::PH_TOTAL) ? k_q[mmf_pkg::IDX_W-1:0]
			                                        : o_q[mmf_pkg::IDX_W-1:0];
			c_addr = (phase_q == mmf_pkg::PH_PRIOR) ? k_q[mmf_pkg::IDX_W-1:0]
			                                        : o_q[mmf_pkg::IDX_W-1:0];
		end
	end

	assign t_we = req_acc && (req.req_type == mmf_pkg::REQ_LOAD) && !ri_bad;
	assign e_we = (state_q == mmf_pkg::ST_WR);

	mmf_ram #(.WIDTH(VB), .DEPTH(mmf_pkg::MAX_BANKS * mmf_pkg::MAX_BANKS)) u_entry (
		.clk   (clk),
		.we    (e_we),
		.addr  (e_addr),
		.wdata (quo_q),
		.rdata (e_rd)
	);

	mmf_ram #(.WIDTH(VB), .DEPTH(mmf_pkg::MAX_BANKS)) u_row_tgt (
		.clk   (clk),
		.we    (t_we),
		.addr  (r_addr),
		.wdata (req.row_target),
		.rdata (r_rd)
	);

	mmf_ram #(.WIDTH(VB), .DEPTH(mmf_pkg::MAX_BANKS)) u_col_tgt (
		.clk   (clk),
		.we    (t_we),
		.addr  (c_addr),
		.wdata (req.col_target),
		.rdata (c_rd)
	);

	// one 48x16 partial product per multiply cycle, top chunk first
	assign pp = opa_q * opb_q[VB-1:VB-16];

	// sequencer: next state and datapath updates
	always_comb begin
		logic [VB-1:0]             sum_in, resid, wnew;
		logic [mmf_pkg::ITER_W-1:0] it_n;
		logic [VB:0]               r2;
		logic                      adv, sum_go, fin, fin_conv;

		state_d     = state_q;
		phase_d     = phase_q;
		o_d         = o_q;
		k_d         = k_q;
		v_d         = v_s1;
		first_d     = first_q;
		it_d        = it_q;
		last_iter_d = last_iter_q;
		mcnt_d      = mcnt_q;
		dcnt_d      = dcnt_q;
		out_valid_d = out_valid_q && rsp_stall;
		acc_d       = acc_q;
		total_d     = total_q;
		d_d         = d_q;
		opa_d       = opa_q;
		opb_d       = opb_q;
		prod_d      = prod_q;
		rem_d       = rem_q;
		quo_d       = quo_q;
		worst_d     = worst_q;
		pend_val_d  = pend_val_q;
		pend_conv_d = pend_conv_q;
		pend_stat_d = pend_stat_q;
		out_d       = out_q;
		adv         = 1'b0;
		sum_go      = 1'b0;
		fin         = 1'b0;
		fin_conv    = 1'b0;
		it_n        = it_q + mmf_pkg::ITER_W'(1);
		sum_in      = (phase_q == mmf_pkg::PH_TOTAL) ? r_rd : e_rd;
		resid       = (acc_q > r_rd) ? acc_q - r_rd : r_rd - acc_q;
		wnew        = (resid > worst_q) ? resid : worst_q;
		r2          = {rem_q, quo_q[VB-1]};

		case (state_q)
			mmf_pkg::ST_IDLE: begin
				if (req_acc) begin
					pend_val_d  = '0;
					pend_conv_d = 1'b0;
					pend_stat_d = 1'b0;
					case (req.req_type)
						mmf_pkg::REQ_LOAD: begin
							pend_stat_d = ri_bad;
							state_d     = mmf_pkg::ST_RESP;
						end
						mmf_pkg::REQ_START: begin
							phase_d = mmf_pkg::PH_TOTAL;
							o_d     = '0;
							first_d = 1'b1;
							it_d    = '0;
							sum_go  = 1'b1;
						end
						mmf_pkg::REQ_READ: begin
							pend_stat_d = ri_bad || ci_bad;
							state_d     = mmf_pkg::ST_READ;
						end
						default: begin
							state_d = mmf_pkg::ST_RESP;
						end
					endcase
				end
			end

			mmf_pkg::ST_READ: begin
				pend_val_d = pend_stat_q ? '0 : e_rd;
				state_d    = mmf_pkg::ST_RESP;
			end

			mmf_pkg::ST_RESP: begin
				if (!out_valid_q || !rsp_stall) begin
					out_valid_d           = 1'b1;
					out_d.result_value    = pend_val_q;
					out_d.iterations_used = last_iter_q;
					out_d.converged       = pend_conv_q;
					out_d.status          = pend_stat_q;
					state_d               = mmf_pkg::ST_IDLE;
				end
			end

			// streamed sum: one RAM word issued per cycle, accumulated once its registered read data returns
			mmf_pkg::ST_SUM: begin
				if (k_q < n_eff) begin
					k_d = k_q + mmf_pkg::CNT_W'(1);
					v_d = 1'b1;
				end else begin
					v_d = 1'b0;
				end
				if (v_s1) begin
					acc_d = mmf_pkg::sat_add(acc_q, sum_in);
				end
				if (k_q == n_eff && !v_s1) begin
					case (phase_q)
						mmf_pkg::PH_TOTAL: begin
							total_d = acc_q;
							d_d     = acc_q;
							phase_d = mmf_pkg::PH_PRIOR;
							o_d     = '0;
							k_d     = '0;
							state_d = mmf_pkg::ST_ELEM_RD;
						end
						mmf_pkg::PH_ROW, mmf_pkg::PH_COL: begin
							if (acc_q == '0) begin
								adv = 1'b1;
							end else begin
								d_d     = acc_q;
								k_d     = '0;
								state_d = mmf_pkg::ST_ELEM_RD;
							end
						end
						mmf_pkg::PH_RES: begin
							if (o_q + mmf_pkg::CNT_W'(1) < n_eff) begin
								worst_d = wnew;
								o_d     = o_q + mmf_pkg::CNT_W'(1);
								sum_go  = 1'b1;
							end else if (first_q) begin
								if (maxit_q == '0) begin
									fin = 1'b1;
								end else begin
									first_d = 1'b0;
									phase_d = mmf_pkg::PH_ROW;
									o_d     = '0;
									sum_go  = 1'b1;
								end
							end else begin
								it_d = it_n;
								if (wnew < tol_q) begin
									fin      = 1'b1;
									fin_conv = 1'b1;
								end else if (it_n == maxit_q) begin
									fin = 1'b1;
								end else begin
									phase_d = mmf_pkg::PH_ROW;
									o_d     = '0;
									sum_go  = 1'b1;
								end
							end
						end
						default: begin
							state_d = mmf_pkg::ST_IDLE;
						end
					endcase
				end
			end

			mmf_pkg::ST_ELEM_RD: begin
				state_d = mmf_pkg::ST_ELEM_LAT;
			end

			// operands available from all three RAMs
			mmf_pkg::ST_ELEM_LAT: begin
				if (phase_q == mmf_pkg::PH_PRIOR && (o_q == k_q || total_q == '0)) begin
					quo_d   = '0;
					state_d = mmf_pkg::ST_WR;
				end else begin
					opa_d   = (phase_q == mmf_pkg::PH_PRIOR) ? r_rd : e_rd;
					opb_d   = (phase_q == mmf_pkg::PH_ROW) ? r_rd : c_rd;
					prod_d  = '0;
					mcnt_d  = '0;
					state_d = mmf_pkg::ST_MUL;
				end
			end

			mmf_pkg::ST_MUL: begin
				prod_d = {prod_q[PB-17:0], 16'd0} + {{(PB-64){1'b0}}, pp};
				opb_d  = {opb_q[VB-17:0], 16'd0};
				mcnt_d = mcnt_q + 2'd1;
				if (mcnt_q == 2'd2) begin
					state_d = mmf_pkg::ST_CHK;
				end
			end

			// quotient too wide or zero divisor saturates
			mmf_pkg::ST_CHK: begin
				if (d_q == '0 || prod_q[PB-1:VB] >= d_q) begin
					quo_d   = '1;
					state_d = mmf_pkg::ST_WR;
				end else begin
					rem_d   = prod_q[PB-1:VB];
					quo_d   = prod_q[VB-1:0];
					dcnt_d  = '0;
					state_d = mmf_pkg::ST_DIV;
				end
			end

			// restoring divide, one quotient bit per cycle
			mmf_pkg::ST_DIV: begin
				if (r2 >= {1'b0, d_q}) begin
					rem_d = VB'(r2 - {1'b0, d_q});
					quo_d = {quo_q[VB-2:0], 1'b1};
				end else begin
					rem_d = r2[VB-1:0];
					quo_d = {quo_q[VB-2:0], 1'b0};
				end
				dcnt_d = dcnt_q + 6'd1;
				if (dcnt_q == 6'(VB - 1)) begin
					state_d = mmf_pkg::ST_WR;
				end
			end

			mmf_pkg::ST_WR: begin
				if (k_q + mmf_pkg::CNT_W'(1) < n_eff) begin
					k_d     = k_q + mmf_pkg::CNT_W'(1);
					state_d = mmf_pkg::ST_ELEM_RD;
				end else begin
					adv = 1'b1;
				end
			end

			default: begin
				state_d = mmf_pkg::ST_IDLE;
			end
		endcase

		// next row or column, or next phase
		if (adv) begin
			case (phase_q)
				mmf_pkg::PH_PRIOR: begin
					if (o_q + mmf_pkg::CNT_W'(1) < n_eff) begin
						o_d     = o_q + mmf_pkg::CNT_W'(1);
						k_d     = '0;
						state_d = mmf_pkg::ST_ELEM_RD;
					end else begin
						phase_d = mmf_pkg::PH_RES;
						o_d     = '0;
						worst_d = '0;
						sum_go  = 1'b1;
					end
				end
				mmf_pkg::PH_ROW: begin
					if (o_q + mmf_pkg::CNT_W'(1) < n_eff) begin
						o_d = o_q + mmf_pkg::CNT_W'(1);
					end else begin
						phase_d = mmf_pkg::PH_COL;
						o_d     = '0;
					end
					sum_go = 1'b1;
				end
				mmf_pkg::PH_COL: begin
					if (o_q + mmf_pkg::CNT_W'(1) < n_eff) begin
						o_d = o_q + mmf_pkg::CNT_W'(1);
					end else begin
						phase_d = mmf_pkg::PH_RES;
						o_d     = '0;
						worst_d = '0;
					end
					sum_go = 1'b1;
				end
				default: begin
					state_d = mmf_pkg::ST_IDLE;
				end
			endcase
		end

		if (sum_go) begin
			k_d     = '0;
			v_d     = 1'b0;
			acc_d   = '0;
			state_d = mmf_pkg::ST_SUM;
		end

		// start finished: report worst residual and pass count
		if (fin) begin
			pend_val_d  = wnew;
			pend_conv_d = fin_conv;
			pend_stat_d = 1'b0;
			last_iter_d = first_q ? '0 : it_n;
			state_d     = mmf_pkg::ST_RESP;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmf_pkg::ST_IDLE;
			phase_q     <= mmf_pkg::PH_TOTAL;
			o_q         <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			first_q     <= 1'b0;
			it_q        <= '0;
			last_iter_q <= '0;
			mcnt_q      <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			bank_q      <= mmf_pkg::CNT_W'(64);
			maxit_q     <= mmf_pkg::ITER_W'(100);
			tol_q       <= VB'(1);
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			o_q         <= o_d;
			k_q         <= k_d;
			v_s1        <= v_d;
			first_q     <= first_d;
			it_q        <= it_d;
			last_iter_q <= last_iter_d;
			mcnt_q      <= mcnt_d;
			dcnt_q      <= dcnt_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mmf_pkg::CFG_BANK_COUNT: bank_q  <= cfg_data[mmf_pkg::CNT_W-1:0];
					mmf_pkg::CFG_MAX_ITER:   maxit_q <= cfg_data[mmf_pkg::ITER_W-1:0];
					mmf_pkg::CFG_TOLERANCE:  tol_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		acc_q       <= acc_d;
		total_q     <= total_d;
		d_q         <= d_d;
		opa_q       <= opa_d;
		opb_q       <= opb_d;
		prod_q      <= prod_d;
		rem_q       <= rem_d;
		quo_q       <= quo_d;
		worst_q     <= worst_d;
		pend_val_q  <= pend_val_d;
		pend_conv_q <= pend_conv_d;
		pend_stat_q <= pend_stat_d;
		out_q       <= out_d;
	end

	// the outer sequencer index stays inside the active matrix while sweeping
	a_outer_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmf_pkg::ST_SUM || state_q == mmf_pkg::ST_WR) |-> (o_q < n_eff))
		else $error("outer index beyond bank count");

	// a new response only comes out of the response state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == mmf_pkg::ST_RESP))
		else $error("response raised outside response state");

	// an accepted request always leaves idle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != mmf_pkg::ST_IDLE))
		else $error("request accepted without leaving idle");

	// entry writes happen only during a fitting run
	a_entry_wr: assert property (@(posedge clk) disable iff (!arst_n)
		e_we |-> (phase_q == mmf_pkg::PH_PRIOR || phase_q == mmf_pkg::PH_ROW
		       || phase_q == mmf_pkg::PH_COL))
		else $error("entry write outside a rescaling phase");

endmodule

`default_nettype wire

>>> hdl/mmf_ram.sv
// ----------------------------------------------------------------------------
// mmf_ram
// Single-port synchronous RAM, registered read (read before write).
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire
